// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with async reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: rtl/lefp_pkg.sv
// ----------------------------------------------------------------------------
// lefp_pkg
// Types and constants shared by the length-prefixed field parser.
// ----------------------------------------------------------------------------
package lefp_pkg;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_LEN14   = 2'd1,
		PH_LEN32   = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_SIZE  = 3'd0,
		KIND_STR   = 3'd1,
		KIND_INT   = 3'd2,
		KIND_EMPTY = 3'd3,
		KIND_UNSUP = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PFX_LEN6  = 2'b00,
		PFX_LEN14 = 2'b01,
		PFX_LEN32 = 2'b10,
		PFX_SPEC  = 2'b11
	} prefix_t;

	localparam logic [7:0]  FIRST_UNSUP_PREFIX = 8'hC3;
	localparam logic [31:0] LEN14_MASK         = 32'h0000_3FFF;
	localparam logic [31:0] LEN32_BYTES        = 32'd4;

	typedef struct packed {
		phase_t      phase;
		logic        field_is_string;
		logic [31:0] assembled_size;
		logic [31:0] bytes_remaining;
		logic        integer_payload;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [31:0] value;
		logic        last;
	} parse_result_t;

endpackage

// File: rtl/lefp_step.sv
// ----------------------------------------------------------------------------
// lefp_step
// Next-state and result logic for one stream byte.
// ----------------------------------------------------------------------------
module lefp_step
	import lefp_pkg::*;
(
	input  parse_state_t  st,
	input  logic [7:0]    data_byte,
	input  logic          mode,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic        len_done;
	logic [31:0] len;
	logic [31:0] asm14;
	logic [31:0] asm32;
	logic [31:0] br_dec;
	logic        pay_last;

	always_comb begin
		nxt      = st;
		res      = '0;
		res.kind = KIND_SIZE;
		len_done = 1'b0;
		len      = '0;
		asm14    = (st.assembled_size | {24'd0, data_byte}) & LEN14_MASK;
		asm32    = {st.assembled_size[23:0], data_byte};
		br_dec   = (st.bytes_remaining != 32'd0) ? st.bytes_remaining - 32'd1
			: st.bytes_remaining;
		pay_last = (st.bytes_remaining <= 32'd1);

		unique case (st.phase)
			PH_LEN14: begin
				nxt.assembled_size = asm14;
				len_done           = 1'b1;
				len                = asm14;
			end
			PH_LEN32: begin
				nxt.assembled_size  = asm32;
				nxt.bytes_remaining = br_dec;
				len_done            = (br_dec == 32'd0);
				len                 = asm32;
			end
			PH_PAYLOAD: begin
				nxt.bytes_remaining = br_dec;
				if (pay_last) begin
					nxt.phase = PH_START;
				end
				res.valid = 1'b1;
				res.kind  = st.integer_payload ? KIND_INT : KIND_STR;
				res.value = {24'd0, data_byte};
				res.last  = pay_last;
			end
			default: begin
				nxt.field_is_string = mode;
				unique case (prefix_t'(data_byte[7:6]))
					PFX_LEN6: begin
						len_done = 1'b1;
						len      = {26'd0, data_byte[5:0]};
					end
					PFX_LEN14: begin
						nxt.assembled_size = {18'd0, data_byte[5:0], 8'd0};
						nxt.phase          = PH_LEN14;
					end
					PFX_LEN32: begin
						nxt.assembled_size  = '0;
						nxt.bytes_remaining = LEN32_BYTES;
						nxt.phase           = PH_LEN32;
					end
					default: begin
						if (mode && (data_byte < FIRST_UNSUP_PREFIX)) begin
							nxt.integer_payload = 1'b1;
							nxt.bytes_remaining = 32'd1 << data_byte[1:0];
							nxt.phase           = PH_PAYLOAD;
						end else begin
							nxt.phase = PH_START;
							res.valid = 1'b1;
							res.kind  = KIND_UNSUP;
							res.value = {24'd0, data_byte};
							res.last  = 1'b1;
						end
					end
				endcase
			end
		endcase

		// Complete length: report it, report an empty string, or open the string payload.
		if (len_done) begin
			if (!nxt.field_is_string) begin
				nxt.phase = PH_START;
				res.valid = 1'b1;
				res.kind  = KIND_SIZE;
				res.value = len;
				res.last  = 1'b1;
			end else if (len == 32'd0) begin
				nxt.phase = PH_START;
				res.valid = 1'b1;
				res.kind  = KIND_EMPTY;
				res.value = '0;
				res.last  = 1'b1;
			end else begin
				nxt.integer_payload = 1'b0;
				nxt.bytes_remaining = len;
				nxt.phase           = PH_PAYLOAD;
			end
		end
	end

endmodule

// File: rtl/length_encoded_field_parser_core.sv
// A byte's result is registered in the result stage after the byte leaves the input stage.
// Throughput: one byte per cycle unless the output stalls; the input register, the parse state and
// the result register all advance together under one stall signal.
// A byte that starts or extends a length, opens a payload or ends a nonzero string length gives
// no result; every other byte produces exactly one.
// Reset (arst_n low, asynchronous): both stages empty, parser at field start.
// ----------------------------------------------------------------------------
// length_encoded_field_parser_core
// Parses length-prefixed fields from a byte stream, one byte per item,
// giving sizes, string or integer payload bytes, and error items.
// ----------------------------------------------------------------------------
module length_encoded_field_parser_core
	import lefp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] value,
	output logic        last
);

	// Input stage: holds one item until the parser can move it on.
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          mode_s1;

	// Result stage.
	logic          valid_s2;
	kind_t         kind_s2;
	logic [31:0]   value_s2;
	logic          last_s2;

	// Parse state, carried from item to item.
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t step_res;

	logic          advance;

	// Advance whenever the result register is free or being drained.
	assign advance  = !valid_s2 || out_ready;
	// Take a new item while the input stage is empty or moving on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			mode_s1 <= mode;
		end
	end

	lefp_step u_step (
		.st        (state_q),
		.data_byte (byte_s1),
		.mode      (mode_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// Commit the parse state only when the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_START;
			state_q.field_is_string <= 1'b0;
			state_q.assembled_size  <= '0;
			state_q.bytes_remaining <= '0;
			state_q.integer_payload <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: a byte that gives no result leaves a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && step_res.valid) begin
			kind_s2  <= step_res.kind;
			value_s2 <= step_res.value;
			last_s2  <= step_res.last;
		end
	end

	assign out_valid = valid_s2;
	assign kind      = kind_s2;
	assign value     = value_s2;
	assign last      = last_s2;

endmodule

// File: rtl/lefp_checker.sv
// ----------------------------------------------------------------------------
// lefp_checker
// Port-level checks on the parser's item channels, bound to the parser core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lefp_checker
	import lefp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [31:0] value,
	input logic        last
);

	`ASSERT_CLK(a_in_hold, clk, arst_n,
		(in_valid && !in_ready) |=> (in_valid && $stable(data_byte) && $stable(mode)),
		"waiting input item changed")
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		(out_valid && !out_ready) |=>
			(out_valid && $stable(kind) && $stable(value) && $stable(last)),
		"stalled result item changed")
	`ASSERT_IMPL(a_single_last, clk, arst_n,
		out_valid && (kind == KIND_SIZE || kind == KIND_EMPTY || kind == KIND_UNSUP),
		last, "single-item field not marked last")
	`ASSERT_IMPL(a_empty_zero, clk, arst_n, out_valid && kind == KIND_EMPTY,
		value == 32'd0, "empty string carries a value")
	`ASSERT_IMPL(a_byte_width, clk, arst_n,
		out_valid && (kind == KIND_STR || kind == KIND_INT || kind == KIND_UNSUP),
		value[31:8] == 24'd0, "byte item wider than a byte")

endmodule

bind length_encoded_field_parser_core lefp_checker u_lefp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.data_byte (data_byte),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.value     (value),
	.last      (last)
);
